/* rtl/rlew_pkg.sv */
// Shared types and constants for the word run-length decoder.
// No dependencies; imported by every module of the block.
package rlew_pkg;

	localparam int WORD_W = 16;
	localparam int PROD_W = 32;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// Register map: index of each register (byte address is 4 * index)
	localparam logic REG_RUN_KEY = 1'b0;

	localparam logic [WORD_W-1:0] RUN_KEY_RESET = 16'hFEFE;

	// Item selector on the input channel
	localparam logic CMD_FEED = 1'b0;
	localparam logic CMD_PULL = 1'b1;

	typedef enum logic [2:0] {
		PH_HDR_LO,
		PH_HDR_HI,
		PH_DATA,
		PH_COUNT,
		PH_VALUE,
		PH_RUN
	} phase_t;

	typedef struct packed {
		logic              word_valid;
		logic [WORD_W-1:0] out_word;
		logic              stream_done;
		logic              run_pending;
		logic              misuse;
	} result_t;

endpackage

/* rtl/rlew_cfg.sv */
// APB register file of the run-length decoder: holds the run key.
// Depends on rlew_pkg.
module rlew_cfg import rlew_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [WORD_W-1:0]     run_key
);

	logic [WORD_W-1:0] run_key_q;
	logic              wr_en;
	logic              sel_key;

	assign pready  = 1'b1;
	assign sel_key = (paddr[2] == REG_RUN_KEY);
	assign wr_en   = psel && penable && pwrite && pready;

	// Write the key in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_key_q <= RUN_KEY_RESET;
		end else if (wr_en && sel_key) begin
			run_key_q <= pwdata[WORD_W-1:0];
		end
	end

	// Read back, zero outside the map
	always_comb begin
		prdata = '0;
		if (sel_key) begin
			prdata = {{(APB_DATA_W-WORD_W){1'b0}}, run_key_q};
		end
	end

	assign run_key = run_key_q;

endmodule

/* rtl/rlew_core.sv */
// Decode state and next-state logic of the run-length decoder.
// Depends on rlew_pkg; one item is processed per step.
module rlew_core import rlew_pkg::*; #(
	parameter int LENGTH_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              cmd,
	input  logic [WORD_W-1:0] data_word,
	input  logic [WORD_W-1:0] run_key,
	output result_t           result
);

	localparam int TGT_W = LENGTH_BITS - 1;

	phase_t             phase_q, phase_n;
	logic [WORD_W-1:0]  len_lo_q, len_lo_n;
	logic [TGT_W-1:0]   target_q, target_n;
	logic [PROD_W-1:0]  produced_q, produced_n;
	logic [WORD_W-1:0]  run_rem_q, run_rem_n;
	logic [WORD_W-1:0]  run_word_q, run_word_n;

	logic [2*WORD_W-1:0] len_full;
	logic [TGT_W-1:0]    target_hdr;
	logic [PROD_W-1:0]   produced_inc;
	logic                reached_inc;
	logic                reached_cur;
	logic                valid;
	logic                bad;
	logic [WORD_W-1:0]   word;

	// Header length, cut to LENGTH_BITS and halved
	assign len_full     = {data_word, len_lo_q};
	assign target_hdr   = len_full[LENGTH_BITS-1:1];
	assign produced_inc = produced_q + PROD_W'(1);
	assign reached_inc  = (produced_inc >= PROD_W'(target_q));
	assign reached_cur  = (produced_q >= PROD_W'(target_q));

	// Next state and result of one item
	always_comb begin
		phase_n    = phase_q;
		len_lo_n   = len_lo_q;
		target_n   = target_q;
		produced_n = produced_q;
		run_rem_n  = run_rem_q;
		run_word_n = run_word_q;
		valid      = 1'b0;
		bad        = 1'b0;
		word       = '0;
		if (cmd == CMD_PULL) begin
			if (run_rem_q == '0) begin
				bad = 1'b1;
			end else begin
				valid      = 1'b1;
				word       = run_word_q;
				produced_n = produced_inc;
				run_rem_n  = run_rem_q - WORD_W'(1);
				if (run_rem_q == WORD_W'(1)) begin
					phase_n = reached_inc ? PH_HDR_LO : PH_DATA;
				end
			end
		end else if (run_rem_q != '0) begin
			bad = 1'b1;
		end else begin
			unique case (phase_q)
				PH_HDR_LO: begin
					len_lo_n = data_word;
					phase_n  = PH_HDR_HI;
				end
				PH_HDR_HI: begin
					target_n   = target_hdr;
					produced_n = '0;
					phase_n    = (target_hdr == '0) ? PH_HDR_LO : PH_DATA;
				end
				PH_COUNT: begin
					run_rem_n = data_word;
					phase_n   = PH_VALUE;
				end
				PH_VALUE: begin
					run_word_n = data_word;
					if (run_rem_q != '0) begin
						phase_n = PH_RUN;
					end else begin
						phase_n = reached_cur ? PH_HDR_LO : PH_DATA;
					end
				end
				default: begin
					if (data_word == run_key) begin
						phase_n = PH_COUNT;
					end else begin
						valid      = 1'b1;
						word       = data_word;
						produced_n = produced_inc;
						phase_n    = reached_inc ? PH_HDR_LO : PH_DATA;
					end
				end
			endcase
		end
	end

	// Advance the state only on a processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR_LO;
			len_lo_q   <= '0;
			target_q   <= '0;
			produced_q <= '0;
			run_rem_q  <= '0;
			run_word_q <= '0;
		end else if (step) begin
			phase_q    <= phase_n;
			len_lo_q   <= len_lo_n;
			target_q   <= target_n;
			produced_q <= produced_n;
			run_rem_q  <= run_rem_n;
			run_word_q <= run_word_n;
		end
	end

	assign result.word_valid  = valid;
	assign result.out_word    = word;
	assign result.stream_done = (phase_n == PH_HDR_LO);
	assign result.run_pending = (run_rem_n != '0);
	assign result.misuse      = bad;

endmodule

/* rtl/rlew_run_length_decoder_unit.sv */
// Word run-length (RLEW) decoder: stream input, stream output, APB key register.
// Depends on rlew_pkg, rlew_cfg and rlew_core.
//
// Input items: s_tuser is the command (feed a stream word, or pull one run word),
// s_tdata the stream word. Every accepted item yields exactly one result item:
// m_tdata is the decoded word, m_tlast marks that the stream target is reached
// (the next fed word is a new header), m_tuser carries word valid, run pending
// and misuse flags.
// An accepted item passes through the input register, then the result register.
// Throughput is one item per cycle while m_tready is high; the decode step is one
// compare, one 32-bit increment and compare and a phase update between the two
// registers.
// Reset clears the phase to "header low word expected", all counters, and
// loads the run key with 0xFEFE. No clearing pass is needed.
// When m_tready is low the result holds in the output register; one further item
// still enters the input register, then s_tready drops until the result is taken.
// The user must write the run key only while no item is in flight; not enforced.
module rlew_run_length_decoder_unit import rlew_pkg::*; #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input channel
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // [15:0] data_word
	input  logic                  s_tuser,   // [0] cmd
	// Result channel
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // [15:0] out_word
	output logic                  m_tlast,   // stream_done
	output logic [2:0]            m_tuser,   // [0] word_valid, [1] run_pending, [2] misuse
	// Configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic              valid_s1;
	logic              cmd_s1;
	logic [WORD_W-1:0] data_s1;
	logic              out_valid_q;
	result_t           result_q;
	result_t           result;
	logic [WORD_W-1:0] run_key;
	logic              advance;

	rlew_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.run_key (run_key)
	);

	// Process the held item when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			data_s1 <= s_tdata;
		end
	end

	rlew_core #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.cmd       (cmd_s1),
		.data_word (data_s1),
		.run_key   (run_key),
		.result    (result)
	);

	// Result register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = result_q.out_word;
	assign m_tlast  = result_q.stream_done;
	assign m_tuser  = {result_q.misuse, result_q.run_pending, result_q.word_valid};

endmodule

/* rtl/rlew_checker.sv */
// Port-level assertions for the run-length decoder, bound to the top level.
// Depends on rlew_pkg and rlew_run_length_decoder_unit.
module rlew_checker import rlew_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [15:0]           m_tdata,
	input logic                  m_tlast,
	input logic [2:0]            m_tuser,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	input logic [APB_DATA_W-1:0] prdata
);

	// An ignored item never carries a word
	a_misuse_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> !m_tuser[0])
		else $error("misuse result carries a word");

	// A finished stream has no run words left
	a_done_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tuser[1])
		else $error("stream done while run pending");

	// No word means a zero data field
	a_idle_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 16'h0000)
		else $error("nonzero data without word valid");

	// A stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A written key reads back on the next cycle while the key stays addressed
	a_key_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[2] == REG_RUN_KEY)
		|=> (paddr[2] != REG_RUN_KEY) || (prdata == APB_DATA_W'($past(pwdata[WORD_W-1:0]))))
		else $error("run key readback differs from the last write");

endmodule

bind rlew_run_length_decoder_unit rlew_checker u_rlew_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata)
);
